// ===== src/keypad_encoder_event_queue_defines.svh =====
// Assertion macros for the keypad and encoder event queue.
`ifndef KEYPAD_ENCODER_EVENT_QUEUE_DEFINES_SVH
`define KEYPAD_ENCODER_EVENT_QUEUE_DEFINES_SVH

`ifndef SYNTHESIS
// Checked on clk_i, off while rst_ni is low.
`define KEQ_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Checked on clk_i, also during reset.
`define KEQ_ASSERT_RST(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define KEQ_ASSERT(name, prop, msg)
`define KEQ_ASSERT_RST(name, prop, msg)
`endif

`endif

// ===== src/keq_pkg.sv =====
// Types and constants shared by the keypad and encoder event queue.
`timescale 1ns / 1ps
package keq_pkg;

  localparam int unsigned SCAN_W = 24;
  localparam int unsigned CODE_W = 5;
  localparam int unsigned DIR_W  = 8;

  localparam logic [1:0] CMD_SCAN   = 2'd0;
  localparam logic [1:0] CMD_EDGE_A = 2'd1;
  localparam logic [1:0] CMD_EDGE_B = 2'd2;
  localparam logic [1:0] CMD_POP    = 2'd3;

  localparam logic [CODE_W-1:0] CODE_CW   = 5'd24;
  localparam logic [CODE_W-1:0] CODE_CCW  = 5'd25;
  localparam logic [CODE_W-1:0] CODE_NONE = 5'd26;

  localparam logic signed [DIR_W-1:0] DIR_MAX   = 8'sd127;
  localparam logic signed [DIR_W-1:0] DIR_MIN   = -8'sd127;
  localparam logic signed [DIR_W-1:0] CCW_LIMIT = -8'sd2;
  localparam logic signed [DIR_W-1:0] CW_LIMIT  = 8'sd2;

  typedef struct packed {
    logic [1:0]        cmd;
    logic [SCAN_W-1:0] scan_first;
    logic [SCAN_W-1:0] scan_second;
    logic              enc_a;
    logic              enc_b;
  } in_t;

  typedef struct packed {
    logic [CODE_W-1:0] key_code;
    logic              key_valid;
    logic [4:0]        fill_count;
    logic              scan_rejected;
  } out_t;

  typedef struct packed {
    logic              push;
    logic [CODE_W-1:0] code;
    logic              pop;
  } fifo_req_t;

endpackage

// ===== src/keq_if.sv =====
// Valid/ready channel interfaces for commands and results.
`timescale 1ns / 1ps
interface keq_in_if;
  logic         valid;
  logic         ready;
  keq_pkg::in_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface keq_out_if;
  logic          valid;
  logic          ready;
  keq_pkg::out_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== src/keq_fifo.sv =====
// Ring event queue that drops its oldest entry when pushed while full.
`timescale 1ns / 1ps
module keq_fifo #(
  parameter int unsigned DEPTH = 16,
  localparam int unsigned CNT_W = $clog2(DEPTH + 1)
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  keq_pkg::fifo_req_t        req_i,
  output logic [CNT_W-1:0]          count_o,
  output logic [keq_pkg::CODE_W-1:0] rd_data_o
);
  import keq_pkg::*;

  localparam int unsigned IDX_W = $clog2(DEPTH);

  logic [CODE_W-1:0] mem [DEPTH];
  logic [CODE_W-1:0] rd_data_q;
  logic [IDX_W-1:0]  rd_q, rd_d, wr_q, wr_d;
  logic [IDX_W-1:0]  rd_inc, wr_inc;
  logic [CNT_W-1:0]  count_q, count_d;
  logic              full, empty, do_pop;

  assign full   = (count_q == CNT_W'(DEPTH));
  assign empty  = (count_q == '0);
  assign do_pop = req_i.pop && !empty;
  assign rd_inc = (rd_q == IDX_W'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
  assign wr_inc = (wr_q == IDX_W'(DEPTH - 1)) ? '0 : wr_q + 1'b1;

  always_comb begin
    rd_d    = rd_q;
    wr_d    = wr_q;
    count_d = count_q;
    if (req_i.push) begin
      wr_d = wr_inc;
      if (full) begin
        // overwrite the oldest slot and move the head past it
        rd_d = rd_inc;
      end else begin
        count_d = count_q + 1'b1;
      end
    end else if (do_pop) begin
      rd_d    = rd_inc;
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q    <= '0;
      wr_q    <= '0;
      count_q <= '0;
    end else begin
      rd_q    <= rd_d;
      wr_q    <= wr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.push) begin
      mem[wr_q] <= req_i.code;
    end
    if (do_pop) begin
      rd_data_q <= mem[rd_q];
    end
  end

  assign count_o   = count_q;
  assign rd_data_o = rd_data_q;

endmodule

// ===== src/keypad_encoder_event_queue.sv =====
// Top level: key release scanner, quadrature decoder and event queue.
//
//  channel  dir  handshake     payload
//  in_i     in   valid/ready   cmd, scan_first, scan_second, enc_a, enc_b
//  out_o    out  valid/ready   key_code, key_valid, fill_count, scan_rejected
//
// A matching scan pair walks the key positions after accept: one key position
// per cycle goes through the release check and the queue write.
// Rejected scans, encoder edges and pops go straight to the result step (pop
// waits on the registered queue read). One item is in work at a time.
// Asynchronous active-low reset clears control state; queue entries are not
// cleared. A result waits in the output register while the next item is
// taken; a finished item holds in its last step until that register frees.
`timescale 1ns / 1ps
`include "keypad_encoder_event_queue_defines.svh"
module keypad_encoder_event_queue #(
  parameter int unsigned QUEUE_DEPTH = 16,
  parameter int unsigned KEY_COUNT   = 24
) (
  input logic        clk_i,
  input logic        rst_ni,
  keq_in_if.sink     in_i,
  keq_out_if.source  out_o
);
  import keq_pkg::*;

  localparam int unsigned CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned KIDX_W = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]              state_q, state_d;
  logic [KIDX_W-1:0]       key_idx_q, key_idx_d;
  logic [SCAN_W-1:0]       rel_q, rel_d;
  logic [SCAN_W-1:0]       image_q, image_d;
  logic signed [DIR_W-1:0] dir_q, dir_d, dir_up, dir_dn;
  logic                    rej_q, rej_d;
  logic                    got_q, got_d;
  logic                    out_valid_q, out_valid_d;
  out_t                    out_data_q, out_data_d;

  fifo_req_t               fifo_req;
  logic [CNT_W-1:0]        fifo_count;
  logic [CODE_W-1:0]       fifo_rd_data;

  logic                    accept, out_free, last_key;
  logic                    enc_push;
  logic [CODE_W-1:0]       enc_code;

  keq_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (fifo_req),
    .count_o   (fifo_count),
    .rd_data_o (fifo_rd_data)
  );

  assign in_i.ready  = (state_q == ST_IDLE);
  assign accept      = in_i.valid && in_i.ready;
  assign out_free    = !out_valid_q || out_o.ready;
  assign last_key    = (key_idx_q == KIDX_W'(KEY_COUNT - 1));
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

  assign dir_up = (dir_q != DIR_MAX) ? dir_q + 8'sd1 : dir_q;
  assign dir_dn = (dir_q != DIR_MIN) ? dir_q - 8'sd1 : dir_q;

  // quadrature decoder, done in the accept cycle
  always_comb begin
    dir_d    = dir_q;
    enc_push = 1'b0;
    enc_code = CODE_CW;
    if (accept) begin
      case (in_i.data.cmd)
        CMD_EDGE_A: begin
          if (in_i.data.enc_a && in_i.data.enc_b) begin
            dir_d    = '0;
            enc_push = (dir_dn <= CCW_LIMIT);
            enc_code = CODE_CCW;
          end else if (in_i.data.enc_a ^ in_i.data.enc_b) begin
            dir_d = dir_up;
          end else if (dir_q < 8'sd0) begin
            dir_d = dir_dn;
          end
        end
        CMD_EDGE_B: begin
          if (in_i.data.enc_a && in_i.data.enc_b) begin
            dir_d    = '0;
            enc_push = (dir_up >= CW_LIMIT);
            enc_code = CODE_CW;
          end else if (in_i.data.enc_a ^ in_i.data.enc_b) begin
            dir_d = dir_dn;
          end else if (dir_q > 8'sd0) begin
            dir_d = dir_up;
          end
        end
        default: begin
          dir_d = dir_q;
        end
      endcase
    end
  end

  always_comb begin
    fifo_req.push = enc_push || ((state_q == ST_SCAN) && rel_q[0]);
    fifo_req.code = (state_q == ST_SCAN) ? CODE_W'(key_idx_q) : enc_code;
    fifo_req.pop  = accept && (in_i.data.cmd == CMD_POP);
  end

  // sequencer: one key position per cycle through the release check
  always_comb begin
    state_d     = state_q;
    key_idx_d   = key_idx_q;
    rel_d       = rel_q;
    image_d     = image_q;
    rej_d       = rej_q;
    got_d       = got_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;

    if (out_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          rej_d   = 1'b0;
          got_d   = 1'b0;
          state_d = ST_DONE;
          if (in_i.data.cmd == CMD_SCAN) begin
            if (in_i.data.scan_first != in_i.data.scan_second) begin
              rej_d = 1'b1;
            end else begin
              rel_d     = ~image_q & in_i.data.scan_first;
              image_d   = in_i.data.scan_first;
              key_idx_d = '0;
              state_d   = ST_SCAN;
            end
          end else if (in_i.data.cmd == CMD_POP) begin
            got_d = (fifo_count != '0);
          end
        end
      end
      ST_SCAN: begin
        rel_d     = rel_q >> 1;
        key_idx_d = key_idx_q + 1'b1;
        if (last_key) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_d              = 1'b1;
          out_data_d.key_code      = got_q ? fifo_rd_data : CODE_NONE;
          out_data_d.key_valid     = got_q;
          out_data_d.fill_count    = 5'(fifo_count);
          out_data_d.scan_rejected = rej_q;
          state_d                  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      key_idx_q   <= '0;
      image_q     <= '1;
      dir_q       <= '0;
      rej_q       <= 1'b0;
      got_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      key_idx_q   <= key_idx_d;
      image_q     <= image_d;
      dir_q       <= dir_d;
      rej_q       <= rej_d;
      got_q       <= got_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rel_q      <= rel_d;
    out_data_q <= out_data_d;
  end

  `KEQ_ASSERT(a_fill_bound, fifo_count <= CNT_W'(QUEUE_DEPTH), "queue count above depth")
  `KEQ_ASSERT(a_pop_drains, (accept && (in_i.data.cmd == CMD_POP) && (fifo_count != '0)) |=> (fifo_count == $past(fifo_count) - 1'b1), "pop did not drain one entry")
  `KEQ_ASSERT(a_reject_no_key, (out_valid_q && out_data_q.scan_rejected) |-> !out_data_q.key_valid, "rejected scan carries a key")
  `KEQ_ASSERT(a_valid_code, (out_valid_q && out_data_q.key_valid) |-> (out_data_q.key_code != CODE_NONE), "popped event reads as none")
  `KEQ_ASSERT_RST(a_reset_quiet, !rst_ni |-> (!out_valid_q && (fifo_count == '0)), "output or queue live in reset")

endmodule

// ===== test/tb.sv =====
// Self-checking testbench for the keypad release queue and quadrature decoder.
`timescale 1ns / 1ps
module tb;
  import keq_pkg::*;

  localparam int unsigned QDEPTH      = 16;
  localparam int unsigned KEYS        = 24;
  localparam int unsigned RANDOM_ITEMS = 600;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned LONG_HOLD   = 400;
  localparam int unsigned DRAIN_WAIT  = 60;

  typedef struct {
    in_t  item;
    bit   typed;
    out_t want;
  } row_t;

  logic clk;
  logic rst_n;

  keq_in_if  in_ch ();
  keq_out_if out_ch ();

  keypad_encoder_event_queue #(
    .QUEUE_DEPTH(QDEPTH),
    .KEY_COUNT  (KEYS)
  ) DUT (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_ch),
    .out_o (out_ch)
  );

  // predicted block state
  logic [SCAN_W-1:0]       held_keys;
  logic signed [DIR_W-1:0] turn_count;
  logic [CODE_W-1:0]       event_fifo[$];

  out_t due_reports[$];
  row_t plan[$];

  bit quiet;
  bit hold_out;
  int unsigned cycles;
  int unsigned items_sent;
  int unsigned results_seen;
  int unsigned faults;
  int unsigned key_events, cw_events, ccw_events, dropped_events;
  int unsigned rejected_scans, empty_pops;
  bit hit_max, hit_min;
  logic [1:0] phase;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb: timeout after %0d cycles, %0d results pending",
               cycles, due_reports.size());
      $display("tb: errors");
      $finish;
    end
  end

  function automatic void push_event(logic [CODE_W-1:0] code);
    // full queue: drop the oldest entry first
    if (event_fifo.size() == QDEPTH) begin
      void'(event_fifo.pop_front());
      dropped_events++;
    end
    event_fifo.push_back(code);
  endfunction

  function automatic void turn_up();
    if (turn_count < DIR_MAX) turn_count = turn_count + 8'sd1;
    if (turn_count == DIR_MAX) hit_max = 1'b1;
  endfunction

  function automatic void turn_down();
    if (turn_count > DIR_MIN) turn_count = turn_count - 8'sd1;
    if (turn_count == DIR_MIN) hit_min = 1'b1;
  endfunction

  function automatic out_t apply_command(in_t it);
    out_t r;
    int k;
    r = '0;
    r.key_code = CODE_NONE;
    case (it.cmd)
      CMD_SCAN: begin
        if (it.scan_first != it.scan_second) begin
          r.scan_rejected = 1'b1;
          rejected_scans++;
        end else begin
          for (k = 0; k < KEYS; k++) begin
            if (!held_keys[k] && it.scan_first[k]) begin
              push_event(CODE_W'(k));
              key_events++;
            end
          end
          held_keys = it.scan_first;
        end
      end
      CMD_EDGE_A: begin
        if (it.enc_a) begin
          if (it.enc_b) begin
            turn_down();
            if (turn_count <= CCW_LIMIT) begin
              push_event(CODE_CCW);
              ccw_events++;
            end
            turn_count = '0;
          end else begin
            turn_up();
          end
        end else if (it.enc_b) begin
          turn_up();
        end else if (turn_count < 8'sd0) begin
          turn_down();
        end
      end
      CMD_EDGE_B: begin
        if (it.enc_b) begin
          if (it.enc_a) begin
            turn_up();
            if (turn_count >= CW_LIMIT) begin
              push_event(CODE_CW);
              cw_events++;
            end
            turn_count = '0;
          end else begin
            turn_down();
          end
        end else if (it.enc_a) begin
          turn_down();
        end else if (turn_count > 8'sd0) begin
          turn_up();
        end
      end
      default: begin
        if (event_fifo.size() != 0) begin
          r.key_code  = event_fifo.pop_front();
          r.key_valid = 1'b1;
        end else begin
          empty_pops++;
        end
      end
    endcase
    r.fill_count = 5'(event_fifo.size());
    return r;
  endfunction

  function automatic in_t make_item(logic [1:0] cmd, logic [SCAN_W-1:0] first,
                                    logic [SCAN_W-1:0] second, logic a, logic b);
    in_t it;
    it.cmd         = cmd;
    it.scan_first  = first;
    it.scan_second = second;
    it.enc_a       = a;
    it.enc_b       = b;
    return it;
  endfunction

  function automatic out_t report(logic [CODE_W-1:0] code, logic valid, logic [4:0] fill,
                                  logic rej);
    out_t r;
    r.key_code      = code;
    r.key_valid     = valid;
    r.fill_count    = fill;
    r.scan_rejected = rej;
    return r;
  endfunction

  function automatic void add(logic [1:0] cmd, logic [SCAN_W-1:0] first,
                              logic [SCAN_W-1:0] second, logic a, logic b,
                              bit typed, out_t want);
    row_t row;
    row.item  = make_item(cmd, first, second, a, b);
    row.typed = typed;
    row.want  = want;
    plan.push_back(row);
  endfunction

  // Offer one item, hold it until accepted, then record its expected result.
  task automatic send_item(input in_t it, input bit typed, input out_t want);
    int gap;
    out_t guess;
    gap = quiet ? 0 : $urandom_range(0, 15);
    if (gap != 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.data  = it;
    in_ch.valid = 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    guess = apply_command(it);
    due_reports.push_back(typed ? want : guess);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send(input logic [1:0] cmd, input logic [SCAN_W-1:0] first,
                      input logic [SCAN_W-1:0] second, input logic a, input logic b);
    send_item(make_item(cmd, first, second, a, b), 1'b0, '0);
  endtask

  // Drive the counter into its limit, then close with a detent edge.
  task automatic wind(input bit up);
    int n;
    n = $urandom_range(130, 140);
    repeat (n) send(up ? CMD_EDGE_A : CMD_EDGE_B, 24'($urandom), 24'($urandom), 1'b1, 1'b0);
    send(up ? CMD_EDGE_B : CMD_EDGE_A, 24'($urandom), 24'($urandom), 1'b1, 1'b1);
  endtask

  // One quadrature step; levels follow 00, 10, 11, 01 by phase.
  task automatic rotate(input bit fwd);
    logic [1:0] nxt;
    logic old_a, new_a, new_b;
    nxt   = fwd ? phase + 2'd1 : phase - 2'd1;
    old_a = (phase == 2'd1) || (phase == 2'd2);
    new_a = (nxt == 2'd1) || (nxt == 2'd2);
    new_b = nxt[1];
    phase = nxt;
    send((new_a != old_a) ? CMD_EDGE_A : CMD_EDGE_B, 24'($urandom), 24'($urandom),
         new_a, new_b);
  endtask

  task automatic scan_pair(input bit agree);
    logic [SCAN_W-1:0] first, flip;
    case ($urandom_range(0, 3))
      0: first = 24'($urandom);
      1: first = held_keys ^ 24'($urandom & $urandom & $urandom);
      2: first = held_keys & ~(24'd1 << $urandom_range(0, SCAN_W - 1));
      default: first = held_keys | 24'($urandom & $urandom);
    endcase
    if ($urandom_range(0, 15) == 0) first = $urandom_range(0, 1) ? '1 : '0;
    if (agree) begin
      send(CMD_SCAN, first, first, 1'($urandom), 1'($urandom));
    end else begin
      flip = $urandom_range(0, 1) ? (24'd1 << $urandom_range(0, SCAN_W - 1)) : 24'($urandom);
      if (flip == '0) flip = 24'd1;
      send(CMD_SCAN, first, first ^ flip, 1'($urandom), 1'($urandom));
    end
  endtask

  // result side: random stalls, one long hold-off on request
  initial begin : result_side
    int gap;
    out_ch.ready = 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      if (hold_out) begin
        hold_out = 1'b0;
        out_ch.ready = 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
      end else begin
        gap = quiet ? 0 : $urandom_range(0, 15);
        if (gap != 0) begin
          out_ch.ready = 1'b0;
          repeat (gap) @(negedge clk);
        end
      end
      out_ch.ready = 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin : check_results
    out_t got, want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = out_ch.data;
      results_seen++;
      if (due_reports.size() == 0) begin
        faults++;
        if (faults <= 10)
          $display("tb: result with nothing expected: code %0d valid %0d fill %0d rej %0d",
                   got.key_code, got.key_valid, got.fill_count, got.scan_rejected);
      end else begin
        want = due_reports.pop_front();
        if (got.key_code !== want.key_code || got.key_valid !== want.key_valid ||
            got.fill_count !== want.fill_count || got.scan_rejected !== want.scan_rejected) begin
          faults++;
          if (faults <= 10)
            $display("tb: result %0d mismatch: code %0d/%0d valid %0d/%0d fill %0d/%0d rej %0d/%0d",
                     results_seen, got.key_code, want.key_code, got.key_valid, want.key_valid,
                     got.fill_count, want.fill_count, got.scan_rejected, want.scan_rejected);
        end
      end
    end
  end

  initial begin : stimulus
    int i, n, seq;
    in_ch.valid = 1'b0;
    in_ch.data  = '0;
    rst_n       = 1'b1;
    held_keys   = '1;
    turn_count  = '0;
    phase       = 2'd0;
    quiet       = 1'b0;
    hold_out    = 1'b0;

    // directed rows; typed expectations only where obvious
    add(CMD_POP, '0, '0, 1'b0, 1'b0, 1'b1, report(CODE_NONE, 1'b0, 5'd0, 1'b0));
    add(CMD_SCAN, 24'h000000, 24'h000001, 1'b0, 1'b0, 1'b1,
        report(CODE_NONE, 1'b0, 5'd0, 1'b1));
    add(CMD_SCAN, 24'h000000, 24'h000000, 1'b1, 1'b1, 1'b1,
        report(CODE_NONE, 1'b0, 5'd0, 1'b0));
    add(CMD_SCAN, 24'hFFFFFF, 24'hFFFFFF, 1'b0, 1'b1, 1'b1,
        report(CODE_NONE, 1'b0, 5'd16, 1'b0));
    add(CMD_POP, 24'hFFFFFF, 24'h000000, 1'b1, 1'b1, 1'b1, report(5'd8, 1'b1, 5'd15, 1'b0));
    add(CMD_SCAN, 24'hFFFFFF, 24'h7FFFFF, 1'b1, 1'b0, 1'b1,
        report(CODE_NONE, 1'b0, 5'd15, 1'b1));
    add(CMD_SCAN, 24'h800001, 24'h800001, 1'b0, 1'b0, 1'b0, '0);
    add(CMD_SCAN, 24'hFFFFFF, 24'hFFFFFF, 1'b0, 1'b0, 1'b0, '0);
    add(CMD_EDGE_A, '0, '0, 1'b1, 1'b0, 1'b0, '0);
    add(CMD_EDGE_B, '0, '0, 1'b1, 1'b1, 1'b0, '0);
    add(CMD_EDGE_A, '1, '1, 1'b0, 1'b1, 1'b0, '0);
    add(CMD_EDGE_A, '1, '1, 1'b0, 1'b0, 1'b0, '0);
    add(CMD_EDGE_B, '0, '1, 1'b0, 1'b0, 1'b0, '0);
    add(CMD_EDGE_B, '1, '0, 1'b1, 1'b0, 1'b0, '0);
    add(CMD_EDGE_B, '0, '0, 1'b0, 1'b1, 1'b0, '0);
    add(CMD_EDGE_A, '0, '0, 1'b1, 1'b1, 1'b0, '0);
    add(CMD_EDGE_B, '0, '0, 1'b1, 1'b0, 1'b0, '0);
    add(CMD_EDGE_A, '0, '0, 1'b0, 1'b0, 1'b0, '0);
    add(CMD_EDGE_A, '0, '0, 1'b1, 1'b1, 1'b0, '0);
    add(CMD_EDGE_B, '0, '0, 1'b0, 1'b0, 1'b0, '0);
    for (i = 0; i < 4; i++) add(CMD_POP, '1, '1, 1'b0, 1'b0, 1'b0, '0);
    add(CMD_SCAN, 24'h000000, 24'h000000, 1'b0, 1'b0, 1'b0, '0);

    // pull reset low after time zero so the asynchronous edge is always seen
    #1;
    rst_n = 1'b0;
    repeat (9) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    foreach (plan[j]) send_item(plan[j].item, plan[j].typed, plan[j].want);

    // random part; the receiver holds off once so the input backs up
    hold_out = 1'b1;
    seq = 0;
    while (items_sent < plan.size() + RANDOM_ITEMS) begin
      seq++;
      quiet = ($urandom_range(0, 4) == 0);
      if (seq == 20) begin
        wind(1'b1);
      end else if (seq == 60) begin
        wind(1'b0);
      end else begin
        n = $urandom_range(0, 99);
        if (n < 35) begin
          scan_pair(1'b1);
        end else if (n < 45) begin
          scan_pair(1'b0);
        end else if (n < 70) begin
          i = $urandom_range(0, 1);
          repeat ($urandom_range(2, 12)) rotate(i[0]);
        end else if (n < 76) begin
          send($urandom_range(0, 1) ? CMD_EDGE_A : CMD_EDGE_B, 24'($urandom), 24'($urandom),
               1'($urandom), 1'($urandom));
        end else begin
          // mostly short pop bursts, now and then a full drain
          repeat ($urandom_range(1, ($urandom_range(0, 3) == 0) ? 20 : 5))
            send(CMD_POP, 24'($urandom), 24'($urandom), 1'($urandom), 1'($urandom));
        end
      end
    end
    quiet = 1'b0;
    in_ch.valid = 1'b0;

    while (due_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("tb: %0d items (%0d directed), %0d results checked, %0d failures",
             items_sent, plan.size(), results_seen, faults);
    $display("tb: %0d key releases, %0d cw, %0d ccw, %0d dropped, %0d rejected,",
             key_events, cw_events, ccw_events, dropped_events, rejected_scans);
    $display("tb: %0d empty pops, limits %0d/%0d", empty_pops, hit_max, hit_min);
    if (faults == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
